// ----- rtl/tia_pkg.sv -----
// Package of the tagged integer ALU: widths, operation and status codes,
// and the lane record carried along the cell chain. No dependencies.
package tia_pkg;
    localparam int PW = 46;
    localparam int WW = 64;

    localparam logic [3:0] OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2,
        OP_DIV = 4'd3, OP_DIVREM = 4'd4, OP_INC = 4'd5, OP_DEC = 4'd6,
        OP_LT = 4'd7, OP_GT = 4'd8, OP_LE = 4'd9, OP_GE = 4'd10,
        OP_EQ = 4'd11, OP_NE = 4'd12, OP_ISINT = 4'd13, OP_NOTINT = 4'd14;

    localparam logic [1:0] ST_OK = 2'd0, ST_FALSE = 2'd1, ST_NOTINT = 2'd2,
        ST_DIVZERO = 2'd3;

    typedef struct packed {
        logic [1:0]    status;
        logic          is_div;
        logic          is_rem;
        logic          is_mul;
        logic          neg_q;
        logic          neg_r;
        logic [PW-1:0] res;
        logic [PW-1:0] qd;
        logic [PW-1:0] dvs;
        logic [PW-1:0] rem;
        logic [PW-1:0] mcd;
        logic [PW-1:0] mlt;
        logic [PW-1:0] prod;
    } t_lane;
endpackage

// ----- rtl/tia_front.sv -----
// Decode stage of the tagged integer ALU: tag checks, the operations done
// at decode and set-up of the divide and multiply lanes. Uses tia_pkg.
module tia_front (
    input  logic [3:0]            i_cmd,
    input  logic [tia_pkg::WW-1:0] i_a,
    input  logic [tia_pkg::WW-1:0] i_b,
    output tia_pkg::t_lane        o_lane
);
    import tia_pkg::*;

    logic          int_a, int_b, both;
    logic [PW-1:0] pa, pb;
    logic          lt, eqp;

    assign int_a = (i_a[WW-1:PW] == '0);
    assign int_b = (i_b[WW-1:PW] == '0);
    assign both  = int_a && int_b;
    assign pa    = i_a[PW-1:0];
    assign pb    = i_b[PW-1:0];
    assign lt    = $signed(pa) < $signed(pb);
    assign eqp   = (pa == pb);

    always_comb begin
        o_lane        = '0;
        o_lane.status = ST_OK;
        o_lane.qd     = pa[PW-1] ? PW'(-pa) : pa;
        o_lane.dvs    = pb[PW-1] ? PW'(-pb) : pb;
        o_lane.mcd    = pa;
        o_lane.mlt    = pb;
        o_lane.neg_q  = pa[PW-1] ^ pb[PW-1];
        o_lane.neg_r  = pa[PW-1];
        case (i_cmd)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DIVREM: begin
                if (!both) begin
                    o_lane.status = ST_NOTINT;
                end else if (i_cmd == OP_ADD) begin
                    o_lane.res = pa + pb;
                end else if (i_cmd == OP_SUB) begin
                    o_lane.res = pa - pb;
                end else if (i_cmd == OP_MUL) begin
                    o_lane.is_mul = 1'b1;
                end else if (pb == '0) begin
                    o_lane.status = ST_DIVZERO;
                end else begin
                    o_lane.is_div = 1'b1;
                    o_lane.is_rem = (i_cmd == OP_DIVREM);
                end
            end
            OP_INC, OP_DEC: begin
                if (!int_a) o_lane.status = ST_NOTINT;
                else o_lane.res = (i_cmd == OP_INC) ? pa + 1'b1 : pa - 1'b1;
            end
            OP_LT, OP_GT, OP_LE, OP_GE: begin
                if (!both) begin
                    o_lane.status = ST_NOTINT;
                end else begin
                    case (i_cmd)
                        OP_LT:   o_lane.status = lt ? ST_OK : ST_FALSE;
                        OP_GT:   o_lane.status = (!lt && !eqp) ? ST_OK : ST_FALSE;
                        OP_LE:   o_lane.status = (lt || eqp) ? ST_OK : ST_FALSE;
                        default: o_lane.status = !lt ? ST_OK : ST_FALSE;
                    endcase
                end
            end
            OP_EQ:     o_lane.status = (i_a == i_b) ? ST_OK : ST_FALSE;
            OP_NE:     o_lane.status = (i_a != i_b) ? ST_OK : ST_FALSE;
            OP_ISINT:  o_lane.status = int_a ? ST_OK : ST_FALSE;
            OP_NOTINT: o_lane.status = int_a ? ST_FALSE : ST_OK;
            default:   o_lane.status = ST_NOTINT;
        endcase
    end
endmodule

// ----- rtl/tia_cell.sv -----
// One cell of the chain: a restoring divide step and a shift-add multiply
// step, registered. Uses tia_pkg.
module tia_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_valid,
    input  tia_pkg::t_lane i_lane,
    output logic           o_valid,
    output tia_pkg::t_lane o_lane
);
    import tia_pkg::*;

    logic [PW:0]   trial;
    logic [PW:0]   diff;
    t_lane         n_lane;
    logic          r_valid;
    t_lane         r_lane;

    assign trial = {i_lane.rem, i_lane.qd[PW-1]};
    assign diff  = trial - {1'b0, i_lane.dvs};

    always_comb begin
        n_lane     = i_lane;
        if (!diff[PW]) begin
            n_lane.rem = diff[PW-1:0];
        end else begin
            n_lane.rem = trial[PW-1:0];
        end
        n_lane.qd   = {i_lane.qd[PW-2:0], ~diff[PW]};
        n_lane.prod = i_lane.mlt[0] ? i_lane.prod + i_lane.mcd : i_lane.prod;
        n_lane.mcd  = {i_lane.mcd[PW-2:0], 1'b0};
        n_lane.mlt  = {1'b0, i_lane.mlt[PW-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
        if (i_load) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
endmodule

// ----- rtl/tagged_integer_alu.sv -----
// Top level of the tagged integer ALU: decode, a chain of divide/multiply
// cells and the output register. Uses tia_pkg, tia_front and tia_cell.
//
// Usage. An operation transaction (i_cmd, i_operand_a, i_operand_b) is
// taken when i_valid is high and o_stall is low. Each transaction yields
// exactly one result transaction (o_status, o_value, o_second_value),
// taken by the receiver when o_valid is high and i_stall is low.
// Every operation, simple or not, travels the same path: the decode stage
// feeds a chain of 46 cells, one per payload bit, each doing one step of
// restoring division and one step of shift-add multiplication, and the
// last cell feeds the output register. The first cell loads on the edge
// that accepts the transaction; each result then passes through every
// cell and the output register, for every operation code.
// Throughput is one transaction per cycle while o_stall is low. Each
// stage of the chain moves on whenever the stage after it is empty or
// moving, so bubbles close up and new transactions are still accepted
// while a finished result waits in the output register; o_stall rises
// only when the whole chain is full behind a stalled output.
// Reset (synchronous, active low) empties the chain and the output
// register; no results are pending afterwards.
module tagged_integer_alu (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [3:0]             i_cmd,
    input  logic [tia_pkg::WW-1:0] i_operand_a,
    input  logic [tia_pkg::WW-1:0] i_operand_b,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic [tia_pkg::PW-1:0] o_value,
    output logic [tia_pkg::PW-1:0] o_second_value
);
    import tia_pkg::*;

    // Lane k is the input of cell k; lane PW is the output of the last cell.
    t_lane         lane  [PW+1];
    logic          v     [PW+1];
    logic          rdy   [PW+1];
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [PW-1:0] r_value, r_second;
    logic [PW-1:0] n_value, n_second;
    logic          out_rdy;

    tia_front u_front (
        .i_cmd  (i_cmd),
        .i_a    (i_operand_a),
        .i_b    (i_operand_b),
        .o_lane (lane[0])
    );
    assign v[0] = i_valid;

    // The output register can take a new result when empty or being drained.
    assign out_rdy = !r_out_valid || !i_stall;
    assign rdy[PW] = out_rdy;

    for (genvar k = 0; k < PW; k++) begin : g_cell
        // A cell may load when it is empty or its own contents move on.
        assign rdy[k] = !v[k+1] || rdy[k+1];
        tia_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (rdy[k]),
            .i_valid (v[k]),
            .i_lane  (lane[k]),
            .o_valid (v[k+1]),
            .o_lane  (lane[k+1])
        );
    end

    assign o_stall = !rdy[0];

    // Final sign fix-up of quotient and remainder, or selection of the
    // product or of the result worked out at decode.
    always_comb begin
        if (lane[PW].is_div) begin
            n_value = lane[PW].neg_q ? PW'(-lane[PW].qd) : lane[PW].qd;
        end else if (lane[PW].is_mul) begin
            n_value = lane[PW].prod;
        end else begin
            n_value = lane[PW].res;
        end
        if (lane[PW].is_rem) begin
            n_second = lane[PW].neg_r ? PW'(-lane[PW].rem) : lane[PW].rem;
        end else begin
            n_second = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_rdy) begin
            r_out_valid <= v[PW];
        end
        if (out_rdy) begin
            r_status <= lane[PW].status;
            r_value  <= n_value;
            r_second <= n_second;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_value        = r_value;
    assign o_second_value = r_second;
endmodule

// ----- test/tb_tagged_integer_alu.sv -----
`timescale 1ns / 100ps
// Testbench of the tagged integer ALU: drives random and directed operation
// transactions, predicts each result and checks it in order. Uses tia_pkg.
module tb_tagged_integer_alu;
    import tia_pkg::*;

    localparam logic [63:0] TAG_BITS = 64'hffffc00000000000;
    localparam logic [PW-1:0] PAY_MIN = {1'b1, {(PW-1){1'b0}}};

    // Expected result of one operation transaction.
    typedef struct {
        logic [1:0]    status;
        logic [PW-1:0] value;
        logic [PW-1:0] second;
    } t_alu_result;

    // Works out the result of one operation from the tagged operands.
    function automatic t_alu_result alu_predict(logic [3:0] cmd, logic [63:0] a,
                                                logic [63:0] b);
        t_alu_result r;
        logic a_int, b_int;
        logic signed [63:0] sa, sb;
        logic [63:0] ma, mb, q, rm;
        r.status = ST_OK;
        r.value = '0;
        r.second = '0;
        a_int = (a & TAG_BITS) == 0;
        b_int = (b & TAG_BITS) == 0;
        sa = {{(64-PW){a[PW-1]}}, a[PW-1:0]};
        sb = {{(64-PW){b[PW-1]}}, b[PW-1:0]};
        case (cmd)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DIVREM: begin
                if (!(a_int && b_int)) begin
                    r.status = ST_NOTINT;
                end else if (cmd == OP_ADD) begin
                    r.value = PW'(sa + sb);
                end else if (cmd == OP_SUB) begin
                    r.value = PW'(sa - sb);
                end else if (cmd == OP_MUL) begin
                    r.value = PW'(sa * sb);
                end else if (b[PW-1:0] == 0) begin
                    r.status = ST_DIVZERO;
                end else begin
                    ma = sa < 0 ? -sa : sa;
                    mb = sb < 0 ? -sb : sb;
                    q = ma / mb;
                    rm = ma % mb;
                    if ((sa < 0) != (sb < 0)) q = -q;
                    if (sa < 0) rm = -rm;
                    r.value = q[PW-1:0];
                    if (cmd == OP_DIVREM) r.second = rm[PW-1:0];
                end
            end
            OP_INC, OP_DEC: begin
                if (!a_int) r.status = ST_NOTINT;
                else r.value = PW'(cmd == OP_INC ? sa + 1 : sa - 1);
            end
            OP_LT, OP_GT, OP_LE, OP_GE: begin
                if (!(a_int && b_int)) r.status = ST_NOTINT;
                else if ((cmd == OP_LT && sa < sb) || (cmd == OP_GT && sa > sb) ||
                         (cmd == OP_LE && sa <= sb) || (cmd == OP_GE && sa >= sb))
                    r.status = ST_OK;
                else r.status = ST_FALSE;
            end
            OP_EQ:     r.status = a == b ? ST_OK : ST_FALSE;
            OP_NE:     r.status = a != b ? ST_OK : ST_FALSE;
            OP_ISINT:  r.status = a_int ? ST_OK : ST_FALSE;
            OP_NOTINT: r.status = a_int ? ST_FALSE : ST_OK;
            default:   r.status = ST_NOTINT;
        endcase
        return r;
    endfunction

    // In-order store of predicted results.
    class t_alu_scoreboard;
        t_alu_result pending[$];
        int errors = 0;

        function void note_operation(logic [3:0] cmd, logic [63:0] a, logic [63:0] b);
            pending.insert(pending.size(), alu_predict(cmd, a, b));
        endfunction

        function void check_result(logic [1:0] st, logic [PW-1:0] v, logic [PW-1:0] s);
            t_alu_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d value=%h second=%h",
                         $time, st, v, s);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (v !== e.value) begin
                $display("%0t: value expected %h actual %h", $time, e.value, v);
                errors++;
            end
            if (s !== e.second) begin
                $display("%0t: second_value expected %h actual %h", $time, e.second, s);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic [3:0]    i_cmd = '0;
    logic [63:0]   i_operand_a = '0;
    logic [63:0]   i_operand_b = '0;
    logic          o_valid;
    logic          i_stall = 1'b1;
    logic [1:0]    o_status;
    logic [PW-1:0] o_value;
    logic [PW-1:0] o_second_value;

    t_alu_scoreboard board = new();
    bit quiet_sender = 1'b0;   // phase with no idling on either side
    bit quiet_receiver = 1'b0;

    tagged_integer_alu uut (.*);

    always #5 i_clk = ~i_clk;

    // Sends one operation transaction, with a random idle gap before it,
    // and holds it until accepted.
    task automatic send_operation(logic [3:0] cmd, logic [63:0] a, logic [63:0] b);
        while (!quiet_sender && $urandom_range(99) < 22) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (o_stall);
        board.note_operation(cmd, a, b);
    endtask

    // A random payload, biased towards the edges of the signed range.
    function automatic logic [PW-1:0] rand_payload();
        case ($urandom_range(5))
            0: return PAY_MIN;
            1: return ~PAY_MIN;
            2: return PW'($urandom_range(7)) - PW'(3);
            3: return PW'($urandom_range(1000)) - PW'(500);
            default: return PW'({$urandom, $urandom});
        endcase
    endfunction

    // Mostly integer words; now and then a word with a random tag.
    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {18'b0, rand_payload()};
        if ($urandom_range(9) == 0) w = {$urandom, $urandom};
        else if ($urandom_range(19) == 0) w[46 + $urandom_range(17)] = 1'b1;
        return w;
    endfunction

    // Receiver: random stalls, one long hold-off to fill the chain up.
    initial begin : receiver
        int cycle;
        cycle = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            cycle++;
            if (cycle >= 300 && cycle < 420)
                i_stall <= 1'b1;
            else
                i_stall <= !quiet_receiver && $urandom_range(99) < 22;
            @(posedge i_clk);
            if (o_valid && !i_stall)
                board.check_result(o_status, o_value, o_second_value);
        end
    end

    initial begin : stimulus
        logic [63:0] a, b;
        logic [3:0] op;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: edges of the payload, every operation, division corner
        // cases, tagged operands and the unused operation code.
        send_operation(OP_ADD, {18'b0, ~PAY_MIN}, 64'd1);
        send_operation(OP_SUB, {18'b0, PAY_MIN}, 64'd1);
        send_operation(OP_MUL, {18'b0, ~PAY_MIN}, {18'b0, ~PAY_MIN});
        send_operation(OP_DIV, {18'b0, PAY_MIN}, {64{1'b1}} >> 18);
        send_operation(OP_DIVREM, {18'b0, PAY_MIN}, {64{1'b1}} >> 18);
        send_operation(OP_DIVREM, 64'd0 - 64'd7 & ~TAG_BITS, 64'd2);
        send_operation(OP_DIVREM, 64'd7, 64'd0 - 64'd2 & ~TAG_BITS);
        send_operation(OP_DIV, 64'd5, 64'd0);
        send_operation(OP_DIVREM, 64'd5, 64'd0);
        send_operation(OP_DIV, 64'd5, TAG_BITS);
        send_operation(OP_INC, {18'b0, ~PAY_MIN}, {64{1'b1}});
        send_operation(OP_DEC, {18'b0, PAY_MIN}, {64{1'b1}});
        send_operation(OP_INC, {64{1'b1}}, 64'd0);
        send_operation(OP_LT, {18'b0, PAY_MIN}, {18'b0, ~PAY_MIN});
        send_operation(OP_GT, {18'b0, PAY_MIN}, {18'b0, ~PAY_MIN});
        send_operation(OP_LE, 64'd3, 64'd3);
        send_operation(OP_GE, 64'd3, {64{1'b1}});
        send_operation(OP_EQ, {64{1'b1}}, {64{1'b1}});
        send_operation(OP_NE, {64{1'b1}}, {64{1'b1}});
        send_operation(OP_ISINT, 64'd1 << 46, 64'd0);
        send_operation(OP_NOTINT, 64'd1 << 63, 64'd0);
        send_operation(OP_ISINT, {18'b0, {PW{1'b1}}}, 64'd0);
        send_operation(4'd15, 64'd1, 64'd1);
        // Random part; a stretch in the middle runs with no idling at all.
        for (int n = 0; n < 700; n++) begin
            quiet_sender = n >= 450 && n < 550;
            quiet_receiver = quiet_sender;
            op = 4'($urandom_range(15));
            a = rand_word();
            b = $urandom_range(3) == 0 ? {$urandom, $urandom} : rand_word();
            if ((op == OP_EQ || op == OP_NE) && $urandom_range(1)) b = a;
            send_operation(op, a, b);
        end
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
